FILE: sv/four_digit_seven_segment_scanner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-digit seven-segment scanner
// Shared property wrappers; every check is clocked on the rising edge and is
// held off while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// Check that holds in every cycle out of reset.
`define FDSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scanner check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

FILE: sv/fdss_pkg.sv
// ----------------------------------------------------------------------------
// Scanner package
// Register indexes, segment codes and the digit-to-segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package fdss_pkg;

  // Number of multiplexed digits; the scanner's digit split is built for four.
  localparam int DigitCount = 4;

  // Segment codes, bits a..g then dp.
  localparam logic [7:0] SegDash  = 8'h40;
  localparam logic [7:0] SegDp    = 8'h80;
  localparam logic [7:0] SegBlank = 8'h00;

  // Reset value of the refresh period register.
  localparam logic [15:0] RefreshPeriodReset = 16'd15000;

  // Largest value that still shows as digits.
  localparam logic [15:0] MaxShown = 16'd9999;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgRefreshPeriod     = 2'd0,
    CfgSegmentsActiveLow = 2'd1,
    CfgDigitActiveHigh   = 2'd2,
    CfgScanRightToLeft   = 2'd3
  } cfg_index_e;

  // Seven-segment pattern of one decimal digit.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0: pat = 8'h3F;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5B;
      4'd3: pat = 8'h4F;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6D;
      4'd6: pat = 8'h7D;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7F;
      4'd9: pat = 8'h6F;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: sv/four_digit_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// Four-digit seven-segment scanner
// Stores segment patterns for a four-digit number and scans the digits of a
// multiplexed display on prescaled timer ticks.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               word
//   in        input      in_valid_i / in_stall_o mode, number, point, enable
//   out       output     out_valid_o/out_stall_i segment_lines, digit_lines
//   cfg       input      cfg_valid_i/cfg_ready_o register index and data
//
// One word is accepted per cycle while the input stall is low; it passes the input
// register, then digit split, pattern build and prescaler, into the output register.
// Reset clears patterns, prescaler and lines, sets the scan index to digit 3
// and loads the register reset values.
// A stalled result holds the result register, then the input register; the
// input stall rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_digit_seven_segment_scanner_defines.svh"

module four_digit_seven_segment_scanner
  import fdss_pkg::*;
#(
  parameter int PRESCALE_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] number_i,
  input  wire logic [1:0]  point_position_i,
  input  wire logic        scan_enable_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       segment_lines_o,
  output logic [3:0]       digit_lines_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int CmpWidth = (PRESCALE_WIDTH > 16) ? PRESCALE_WIDTH : 16;

  // Configuration registers.
  logic [15:0] refresh_period_q;
  logic        segments_active_low_q;
  logic        digit_active_high_q;
  logic        scan_right_to_left_q;

  // Input register.
  logic        in_valid_q;
  logic        mode_q;
  logic [15:0] number_q;
  logic [1:0]  point_q;
  logic        enable_q;

  // Display state.
  logic [7:0]                patterns_q [DigitCount];
  logic [7:0]                patterns_d [DigitCount];
  logic [1:0]                scan_index_q, scan_index_d;
  logic [PRESCALE_WIDTH-1:0] prescale_q, prescale_d;
  logic [7:0]                seg_drive_q, seg_drive_d;
  logic [3:0]                digit_drive_q, digit_drive_d;

  // Result register.
  logic       out_valid_q;
  logic [7:0] out_seg_q;
  logic [3:0] out_digit_q;

  logic out_blocked;
  logic advance;
  logic in_take;
  logic scan_fire;

  // Handshake: the input register drains whenever the result register can move.
  assign out_blocked = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !out_blocked;
  assign in_stall_o  = in_valid_q && out_blocked;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q      <= RefreshPeriodReset;
      segments_active_low_q <= 1'b0;
      digit_active_high_q   <= 1'b1;
      scan_right_to_left_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgRefreshPeriod:     refresh_period_q      <= cfg_data_i;
        CfgSegmentsActiveLow: segments_active_low_q <= cfg_data_i[0];
        CfgDigitActiveHigh:   digit_active_high_q   <= cfg_data_i[0];
        CfgScanRightToLeft:   scan_right_to_left_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q   <= mode_i;
      number_q <= number_i;
      point_q  <= point_position_i;
      enable_q <= scan_enable_i;
    end
  end

  // Decimal split by reciprocal multiplication; exact for values up to 9999.
  logic [13:0] num14;
  logic [26:0] prod1000, prod100, prod10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [13:0] q10x10;
  logic [9:0]  q100x10;
  logic [6:0]  q1000x10;
  logic [3:0]  digits [DigitCount];

  assign num14    = number_q[13:0];
  assign prod1000 = {13'd0, num14} * 27'd8389;
  assign prod100  = {13'd0, num14} * 27'd5243;
  assign prod10   = {13'd0, num14} * 27'd6554;
  assign q1000    = prod1000[26:23];
  assign q100     = prod100[25:19];
  assign q10      = prod10[25:16];

  assign q10x10   = 14'({q10, 3'b000}) + 14'({q10, 1'b0});
  assign q100x10  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
  assign q1000x10 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});

  assign digits[0] = 4'(num14 - q10x10);
  assign digits[1] = 4'(q10 - q100x10);
  assign digits[2] = 4'(q100 - q1000x10);
  assign digits[3] = q1000;

  // Pattern build: table, leading-zero blanking or decimal point, dashes.
  logic [7:0] raw_pat [DigitCount];
  logic       over_range;

  assign over_range = number_q > MaxShown;

  always_comb begin
    for (int k = 0; k < DigitCount; k++) begin
      raw_pat[k] = seg_pattern(digits[k]);
    end
    if (point_q == 2'd0) begin
      if (digits[3] == 4'd0) begin
        raw_pat[3] = SegBlank;
        if (digits[2] == 4'd0) begin
          raw_pat[2] = SegBlank;
          if (digits[1] == 4'd0) begin
            raw_pat[1] = SegBlank;
          end
        end
      end
    end else begin
      raw_pat[point_q] = raw_pat[point_q] | SegDp;
    end
    if (over_range) begin
      for (int k = 0; k < DigitCount; k++) begin
        raw_pat[k] = SegDash;
      end
    end
  end

  // Prescaler limit saturates when the count is narrower than the period.
  logic [CmpWidth-1:0]       period_ext, mask_ext;
  logic [PRESCALE_WIDTH-1:0] limit;
  logic                      expired;

  assign period_ext = CmpWidth'(refresh_period_q);
  assign mask_ext   = CmpWidth'({PRESCALE_WIDTH{1'b1}});
  assign limit      = (period_ext > mask_ext) ? {PRESCALE_WIDTH{1'b1}}
                                              : PRESCALE_WIDTH'(period_ext);
  assign expired    = prescale_q >= limit;
  assign scan_fire  = advance && mode_q && expired && enable_q;

  // Next display state for the word in the input register.
  always_comb begin
    patterns_d    = patterns_q;
    scan_index_d  = scan_index_q;
    prescale_d    = prescale_q;
    seg_drive_d   = seg_drive_q;
    digit_drive_d = digit_drive_q;
    if (advance) begin
      if (!mode_q) begin
        for (int k = 0; k < DigitCount; k++) begin
          patterns_d[k] = segments_active_low_q ? ~raw_pat[k] : raw_pat[k];
        end
      end else if (expired) begin
        prescale_d = '0;
        if (enable_q) begin
          seg_drive_d   = patterns_q[scan_index_q];
          digit_drive_d = 4'b0001 << scan_index_q;
          scan_index_d  = scan_right_to_left_q ? scan_index_q + 2'd1
                                               : scan_index_q - 2'd1;
        end
      end else begin
        prescale_d = prescale_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DigitCount; k++) begin
        patterns_q[k] <= SegBlank;
      end
      scan_index_q  <= 2'd3;
      prescale_q    <= '0;
      seg_drive_q   <= 8'd0;
      digit_drive_q <= 4'd0;
    end else begin
      patterns_q    <= patterns_d;
      scan_index_q  <= scan_index_d;
      prescale_q    <= prescale_d;
      seg_drive_q   <= seg_drive_d;
      digit_drive_q <= digit_drive_d;
    end
  end

  // Result register: lines as they stand after this word, digit polarity applied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_seg_q   <= seg_drive_d;
      out_digit_q <= digit_active_high_q ? digit_drive_d : ~digit_drive_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_lines_o = out_seg_q;
  assign digit_lines_o   = out_digit_q;

  // At most one digit is ever driven on.
  `FDSS_ASSERT_ALWAYS(a_one_digit_on, clk_i, rst_ni, $onehot0(digit_drive_q))
  // A scan drives exactly the digit that the scan index pointed at.
  `FDSS_ASSERT_NEXT(a_scan_digit, clk_i, rst_ni, scan_fire,
                    digit_drive_q == (4'b0001 << $past(scan_index_q)))
  // A word held behind a stalled result is not dropped.
  `FDSS_ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && out_blocked, in_valid_q)
  // Every word that leaves the input register shows up as a result.
  `FDSS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, advance, out_valid_q)

endmodule

`default_nettype wire
